### design/micu_pkg.sv
package micu_pkg;

  // Operand and result width
  localparam int WIDTH = 32;
  // Bit counter width for the serial units
  localparam int CNT_W = $clog2(WIDTH);

  // Command codes
  localparam logic [1:0] CMD_GCD   = 2'd0;
  localparam logic [1:0] CMD_INV   = 2'd1;
  localparam logic [1:0] CMD_SOLVE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOINV   = 2'd1;
  localparam logic [1:0] ST_ZEROMOD = 2'd2;

endpackage

### design/micu_div.sv
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module micu_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [micu_pkg::WIDTH-1:0] dividend_i,
  input  logic [micu_pkg::WIDTH-1:0] divisor_i,
  output logic                      done_o,
  output logic [micu_pkg::WIDTH-1:0] quotient_o,
  output logic [micu_pkg::WIDTH-1:0] remainder_o
);

  logic                        busy_q, done_q;
  logic [micu_pkg::CNT_W-1:0]  cnt_q;
  logic [micu_pkg::WIDTH-1:0]  rem_q, quo_q, div_q;
  logic [micu_pkg::WIDTH:0]    trial;
  logic [micu_pkg::WIDTH-1:0]  trial_sub;
  logic                        fits;

  // Trial subtraction of the shifted partial remainder; the difference fits in
  // WIDTH bits whenever it is kept
  assign trial     = {rem_q, quo_q[micu_pkg::WIDTH-1]};
  assign trial_sub = trial[micu_pkg::WIDTH-1:0] - div_q;
  assign fits      = (trial >= {1'b0, div_q});

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= micu_pkg::CNT_W'(micu_pkg::WIDTH - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial_sub : trial[micu_pkg::WIDTH-1:0];
      quo_q <= {quo_q[micu_pkg::WIDTH-2:0], fits};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### design/modular_inverse_congruence_unit.sv
// Gcd, modular inverse and linear congruence solver. One item is taken at a
// time: in_ready_o is high only while the sequencer is idle. Each Euclid step
// runs through a shared serial divider; for the inverse each step also runs a
// shift-and-add modular multiply, one mod-add per cycle, and solve adds one
// more reduction and multiply. Zero modulus and the unused command go
// straight to the done state. A finished result sits in the output register
// while the next item is taken.
module modular_inverse_congruence_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 cmd_i,
  input  logic [micu_pkg::WIDTH-1:0] operand_a_i,
  input  logic [micu_pkg::WIDTH-1:0] operand_b_i,
  input  logic [micu_pkg::WIDTH-1:0] modulus_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [micu_pkg::WIDTH-1:0] value_o,
  output logic [1:0]                 status_o
);

  localparam int W = micu_pkg::WIDTH;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GCD  = 4'd1;
  localparam logic [3:0] S_RED  = 4'd2;
  localparam logic [3:0] S_LOOP = 4'd3;
  localparam logic [3:0] S_QDIV = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_SUB  = 4'd6;
  localparam logic [3:0] S_BRED = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]                 state_q, state_d;
  logic [1:0]                 cmd_q;
  logic [W-1:0]               b_q, m_q, r0_q, r1_q, s0_q, s1_q;
  logic [W-1:0]               acc_q, mx_q, my_q, res_q;
  logic [1:0]                 st_q;
  logic [micu_pkg::CNT_W-1:0] cnt_q;
  logic                       phase_q, fin_q;
  logic                       out_valid_q;
  logic [W-1:0]               value_q;
  logic [1:0]                 status_q;

  logic         accept;
  logic         div_start, div_done;
  logic [W-1:0] div_a, div_b, div_quo, div_rem;
  logic [W-1:0] add_y;
  logic [W:0]   add_sum;
  logic [W-1:0] addm_res;
  logic [W-1:0] sub_diff, subm_res;
  logic         mul_last;

  assign accept = in_valid_i && (state_q == S_IDLE);

  // Shared serial divider
  micu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  // Mod-add unit: doubling in phase 0, adding the multiplicand in phase 1
  assign add_y    = phase_q ? mx_q : acc_q;
  assign add_sum  = {1'b0, acc_q} + {1'b0, add_y};
  assign addm_res = (add_sum >= {1'b0, m_q}) ? W'(add_sum - {1'b0, m_q}) : add_sum[W-1:0];

  // Mod-subtract for the next Bezout coefficient
  assign sub_diff = s0_q - acc_q;
  assign subm_res = (s0_q >= acc_q) ? sub_diff : sub_diff + m_q;

  assign mul_last = (cnt_q == '0) && (phase_q || !my_q[W-1]);

  // Divider request selection
  always_comb begin
    div_start = 1'b0;
    div_a     = r0_q;
    div_b     = r1_q;
    case (state_q)
      S_IDLE: begin
        div_a = operand_a_i;
        if (accept) begin
          if (cmd_i == micu_pkg::CMD_GCD) begin
            div_b     = operand_b_i;
            div_start = (operand_b_i != '0);
          end else if (cmd_i == micu_pkg::CMD_INV || cmd_i == micu_pkg::CMD_SOLVE) begin
            div_b     = modulus_i;
            div_start = (modulus_i != '0);
          end
        end
      end
      S_GCD: begin
        div_a     = r1_q;
        div_b     = div_rem;
        div_start = div_done && (div_rem != '0);
      end
      S_LOOP: begin
        if (r1_q != '0) begin
          div_start = 1'b1;
        end else begin
          div_a     = b_q;
          div_b     = m_q;
          div_start = (r0_q == W'(1)) && (cmd_q == micu_pkg::CMD_SOLVE);
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i == micu_pkg::CMD_GCD) begin
            state_d = (operand_b_i != '0) ? S_GCD : S_DONE;
          end else if (cmd_i == micu_pkg::CMD_INV || cmd_i == micu_pkg::CMD_SOLVE) begin
            state_d = (modulus_i != '0) ? S_RED : S_DONE;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_GCD:  if (div_done && div_rem == '0) state_d = S_DONE;
      S_RED:  if (div_done) state_d = S_LOOP;
      S_LOOP: begin
        if (r1_q != '0) begin
          state_d = S_QDIV;
        end else if (r0_q == W'(1) && cmd_q == micu_pkg::CMD_SOLVE) begin
          state_d = S_BRED;
        end else begin
          state_d = S_DONE;
        end
      end
      S_QDIV: if (div_done) state_d = S_MUL;
      S_MUL:  if (mul_last) state_d = fin_q ? S_DONE : S_SUB;
      S_SUB:  state_d = S_LOOP;
      S_BRED: if (div_done) state_d = S_MUL;
      S_DONE: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_q <= cmd_i;
          b_q   <= operand_b_i;
          m_q   <= modulus_i;
          s0_q  <= '0;
          s1_q  <= (modulus_i == W'(1)) ? '0 : W'(1);
          res_q <= '0;
          st_q  <= micu_pkg::ST_OK;
          if (cmd_i == micu_pkg::CMD_GCD) begin
            r0_q  <= operand_a_i;
            r1_q  <= operand_b_i;
            res_q <= operand_a_i;
          end else if (cmd_i == micu_pkg::CMD_INV || cmd_i == micu_pkg::CMD_SOLVE) begin
            r0_q <= modulus_i;
            if (modulus_i == '0) st_q <= micu_pkg::ST_ZEROMOD;
          end
        end
      end
      S_GCD: begin
        if (div_done) begin
          r0_q  <= r1_q;
          r1_q  <= div_rem;
          res_q <= r1_q;
        end
      end
      S_RED: begin
        if (div_done) r1_q <= div_rem;
      end
      S_LOOP: begin
        if (r1_q == '0) begin
          if (r0_q != W'(1)) begin
            st_q  <= micu_pkg::ST_NOINV;
            res_q <= '0;
          end else begin
            res_q <= s0_q;
          end
        end
      end
      S_QDIV: begin
        if (div_done) begin
          // q can equal m only on the first step; q mod m is then zero
          mx_q    <= (div_quo == m_q) ? '0 : div_quo;
          my_q    <= s1_q;
          acc_q   <= '0;
          cnt_q   <= micu_pkg::CNT_W'(W - 1);
          phase_q <= 1'b0;
          fin_q   <= 1'b0;
          r0_q    <= r1_q;
          r1_q    <= div_rem;
        end
      end
      S_BRED: begin
        if (div_done) begin
          mx_q    <= s0_q;
          my_q    <= div_rem;
          acc_q   <= '0;
          cnt_q   <= micu_pkg::CNT_W'(W - 1);
          phase_q <= 1'b0;
          fin_q   <= 1'b1;
        end
      end
      S_MUL: begin
        acc_q <= addm_res;
        if (!phase_q && my_q[W-1]) begin
          phase_q <= 1'b1;
        end else begin
          phase_q <= 1'b0;
          my_q    <= {my_q[W-2:0], 1'b0};
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
        end
        if (mul_last && fin_q) res_q <= addm_res;
      end
      S_SUB: begin
        s0_q <= s1_q;
        s1_q <= subm_res;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      value_q  <= res_q;
      status_q <= st_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule
